// ===== rtl/core/pdq0_pkg.sv =====
// ----------------------------------------------------------------------------
// pdq0_pkg: shared types, constants and functions of the dq0 transform
// quarter-wave sine table builder, fixed-point widths and rounding constants
// ----------------------------------------------------------------------------
`default_nettype none

package pdq0_pkg;

   // sizing
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SAMPLE_WIDTH     = 16;
   localparam int ANGLE_WIDTH      = 16;
   localparam int FRAC_BITS        = 14;

   // table entries run 0 .. 2^FRAC_BITS, signed trig values one bit wider
   localparam int TABLE_BITS = FRAC_BITS + 1;
   localparam int TRIG_BITS  = TABLE_BITS + 1;
   localparam int IDX_BITS   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int POS_BITS   = ANGLE_WIDTH - 2;

   // arithmetic widths
   localparam int PROD_BITS = SAMPLE_WIDTH + TRIG_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;

   // forward divisor is 3 * 2^(FRAC_BITS-1): shift first, then divide by three
   localparam int FWD_SHIFT  = FRAC_BITS - 1;
   localparam int FWD_ROUND  = 3 * (2 ** (FWD_SHIFT - 1));
   localparam int INV_SHIFT  = FRAC_BITS;
   localparam int INV_ROUND  = 2 ** (FRAC_BITS - 1);
   localparam int ZERO_ROUND = 1;
   localparam int MAG_BITS   = SUM_BITS - FWD_SHIFT;
   localparam int VAL_BITS   = MAG_BITS + 2;

   // divide by three as multiply by reciprocal, exact for values below 2^MAG_BITS
   localparam int DIV3_SHIFT = MAG_BITS + 1;
   localparam logic [DIV3_SHIFT-1:0] DIV3_MUL =
      DIV3_SHIFT'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

   // angle constants
   localparam logic [ANGLE_WIDTH-1:0] THIRD_TURN =
      ANGLE_WIDTH'((64'd1 << ANGLE_WIDTH) / 64'd3);

   // stream packing
   localparam int IN_DATA_BITS   = ANGLE_WIDTH + 3 * SAMPLE_WIDTH;
   localparam int IN_TDATA_BITS  = ((IN_DATA_BITS + 7) / 8) * 8;
   localparam int OUT_DATA_BITS  = 3 * SAMPLE_WIDTH;
   localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;

   // opcodes
   localparam logic OP_FORWARD = 1'b0;
   localparam logic OP_INVERSE = 1'b1;

   // taylor series of sine in Q30
   localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
   localparam int          Q30_TO_TABLE = 30 - FRAC_BITS;
   localparam int          TAYLOR_TERMS = 7;

   typedef logic [TABLE_BITS-1:0] sine_table_type [0:SINE_TABLE_DEPTH];

   // divide a taylor term by (2n)(2n+1)
   function automatic logic [63:0] taylor_div(input logic [63:0] term, input int n);
      logic [63:0] res;
      case (n)
         1:       res = term / 64'd6;
         2:       res = term / 64'd20;
         3:       res = term / 64'd42;
         4:       res = term / 64'd72;
         5:       res = term / 64'd110;
         6:       res = term / 64'd156;
         7:       res = term / 64'd210;
         default: res = term;
      endcase
      return res;
   endfunction

   // quarter wave of sine, Q1.14, rounded half up
   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    term;
      longint         acc;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
         x2   = (x * x) >> 30;
         term = x;
         acc  = longint'(x);
         for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = taylor_div((term * x2) >> 30, n);
            if ((n % 2) == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         tbl[i] = TABLE_BITS'((64'(acc) + (64'd1 << (Q30_TO_TABLE - 1))) >> Q30_TO_TABLE);
      end
      return tbl;
   endfunction

   // floor(m / 3)
   function automatic logic [MAG_BITS-1:0] div3(input logic [MAG_BITS-1:0] m);
      logic [MAG_BITS+DIV3_SHIFT-1:0] p;
      p = (MAG_BITS + DIV3_SHIFT)'(m) * (MAG_BITS + DIV3_SHIFT)'(DIV3_MUL);
      return p[DIV3_SHIFT +: MAG_BITS];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/park_dq0_transform.sv =====
// ----------------------------------------------------------------------------
// park_dq0_transform: fixed-point park (dq0) transform, forward and inverse
// streaming unit, one beat per cycle unless the result side stalls, five-stage pipeline, saturating outputs
// ----------------------------------------------------------------------------
// The block takes one beat per clock while the result side does not stall
// and returns one result beat for every input beat, in order. Each beat
// passes through the pipeline: input register, sine table read (one
// dual-read table per phase, registered), the six multipliers, the sums
// with rounding, and the divide-by-three and saturation into the output
// register. Each stage holds its beat only while the stage after it is
// full, so bubbles close up and new beats keep coming in while a finished
// result waits to be taken. Opcode zero maps phases a, b, c to q, d, zero;
// opcode one maps q, d, zero back to a, b, c. The angle is a binary
// fraction of a turn, values are Q1.14, and the result flag in rsp_tuser is
// set when any of the three outputs was clipped.
`default_nettype none

module park_dq0_transform (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // angle, in_first, in_second, in_third (lowest bits first)
   input  logic [pdq0_pkg::IN_TDATA_BITS-1:0]    req_tdata,
   // opcode
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // out_first, out_second, out_third (lowest bits first)
   output logic [pdq0_pkg::OUT_TDATA_BITS-1:0]   rsp_tdata,
   // saturated
   output logic                                  rsp_tuser
);

   localparam int SW    = pdq0_pkg::SAMPLE_WIDTH;
   localparam int AW    = pdq0_pkg::ANGLE_WIDTH;
   localparam int TB    = pdq0_pkg::TABLE_BITS;
   localparam int TRB   = pdq0_pkg::TRIG_BITS;
   localparam int IB    = pdq0_pkg::IDX_BITS;
   localparam int PB    = pdq0_pkg::POS_BITS;
   localparam int PRB   = pdq0_pkg::PROD_BITS;
   localparam int SB    = pdq0_pkg::SUM_BITS;
   localparam int MB    = pdq0_pkg::MAG_BITS;
   localparam int VB    = pdq0_pkg::VAL_BITS;
   localparam int NSTG  = 5;

   localparam logic [IB-1:0] DEPTH_IDX = IB'(pdq0_pkg::SINE_TABLE_DEPTH);

   localparam logic signed [VB-1:0] VAL_MAX = VB'((64'd1 << (SW - 1)) - 64'd1);
   localparam logic signed [VB-1:0] VAL_MIN = -VAL_MAX - VB'(1);
   localparam logic signed [SW-1:0] OUT_MAX = SW'(VAL_MAX);
   localparam logic signed [SW-1:0] OUT_MIN = SW'(VAL_MIN);

   // constant quarter-wave rom, read at sin and cos address for each phase
   localparam pdq0_pkg::sine_table_type SINE_ROM = pdq0_pkg::build_sine_table();

   // ------------------------------------------------------------------------
   // pipeline flow control: a stage loads when empty or when the next loads
   // ------------------------------------------------------------------------
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] stage_en;

   always_comb begin
      stage_en[NSTG-1] = !vld_ff[NSTG-1] || rsp_tready;
      for (int s = NSTG - 2; s >= 0; s--) begin
         stage_en[s] = !vld_ff[s] || stage_en[s+1];
      end
      vld_in[0] = stage_en[0] ? req_tvalid : vld_ff[0];
      for (int s = 1; s < NSTG; s++) begin
         vld_in[s] = stage_en[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = stage_en[0];

   // ------------------------------------------------------------------------
   // stage 0: input register
   // ------------------------------------------------------------------------
   logic                 s0_op_ff;
   logic [AW-1:0]        s0_angle_ff;
   logic signed [SW-1:0] s0_x_ff [3];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_op_ff    <= req_tuser;
         s0_angle_ff <= req_tdata[0 +: AW];
         for (int k = 0; k < 3; k++) begin
            s0_x_ff[k] <= req_tdata[AW + k * SW +: SW];
         end
      end
   end

   // phase angles and table addresses; cos is sin a quarter turn on
   logic [AW-1:0]    ang      [3];
   logic [IB-1:0]    sin_addr [3];
   logic [IB-1:0]    cos_addr [3];
   logic [2:0]       sin_neg;
   logic [2:0]       cos_neg;

   always_comb begin
      logic [1:0]       quad;
      logic [1:0]       quad_c;
      logic [PB-1:0]    pos;
      logic [PB+IB-1:0] scaled;
      logic [IB-1:0]    idx;
      logic [IB-1:0]    idx_flip;
      ang[0] = s0_angle_ff;
      ang[1] = s0_angle_ff - pdq0_pkg::THIRD_TURN;
      ang[2] = s0_angle_ff + pdq0_pkg::THIRD_TURN;
      for (int k = 0; k < 3; k++) begin
         quad     = ang[k][AW-1 -: 2];
         quad_c   = quad + 2'd1;
         pos      = ang[k][PB-1:0];
         scaled   = (PB + IB)'(pos) * (PB + IB)'(pdq0_pkg::SINE_TABLE_DEPTH);
         idx      = scaled[PB +: IB];
         idx_flip = DEPTH_IDX - idx;
         sin_addr[k] = quad[0]   ? idx_flip : idx;
         cos_addr[k] = quad_c[0] ? idx_flip : idx;
         sin_neg[k]  = quad[1];
         cos_neg[k]  = quad_c[1];
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: registered table reads
   // ------------------------------------------------------------------------
   logic                 s1_op_ff;
   logic [TB-1:0]        s1_sin_ff [3];
   logic [TB-1:0]        s1_cos_ff [3];
   logic [2:0]           s1_sin_neg_ff;
   logic [2:0]           s1_cos_neg_ff;
   logic signed [SW-1:0] s1_x_ff [3];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_op_ff      <= s0_op_ff;
         s1_sin_neg_ff <= sin_neg;
         s1_cos_neg_ff <= cos_neg;
         for (int k = 0; k < 3; k++) begin
            s1_sin_ff[k] <= SINE_ROM[sin_addr[k]];
            s1_cos_ff[k] <= SINE_ROM[cos_addr[k]];
            s1_x_ff[k]   <= s0_x_ff[k];
         end
      end
   end

   // signed trig values and the six products
   logic signed [PRB-1:0] pc_in [3];
   logic signed [PRB-1:0] ps_in [3];

   always_comb begin
      logic signed [TRB-1:0] sin_v;
      logic signed [TRB-1:0] cos_v;
      logic signed [SW-1:0]  op_c;
      logic signed [SW-1:0]  op_s;
      for (int k = 0; k < 3; k++) begin
         sin_v = s1_sin_neg_ff[k] ? -signed'({1'b0, s1_sin_ff[k]}) : signed'({1'b0, s1_sin_ff[k]});
         cos_v = s1_cos_neg_ff[k] ? -signed'({1'b0, s1_cos_ff[k]}) : signed'({1'b0, s1_cos_ff[k]});
         // forward weighs each phase, inverse weighs q and d
         op_c  = (s1_op_ff == pdq0_pkg::OP_FORWARD) ? s1_x_ff[k] : s1_x_ff[0];
         op_s  = (s1_op_ff == pdq0_pkg::OP_FORWARD) ? s1_x_ff[k] : s1_x_ff[1];
         pc_in[k] = PRB'(cos_v) * PRB'(op_c);
         ps_in[k] = PRB'(sin_v) * PRB'(op_s);
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: product registers
   // ------------------------------------------------------------------------
   logic                  s2_op_ff;
   logic signed [PRB-1:0] s2_pc_ff [3];
   logic signed [PRB-1:0] s2_ps_ff [3];
   logic signed [SW-1:0]  s2_x_ff  [3];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s2_op_ff <= s1_op_ff;
         for (int k = 0; k < 3; k++) begin
            s2_pc_ff[k] <= pc_in[k];
            s2_ps_ff[k] <= ps_in[k];
            s2_x_ff[k]  <= s1_x_ff[k];
         end
      end
   end

   // sums, then magnitude rounded half away from zero and shifted
   logic [MB-1:0] mag_in [3];
   logic [2:0]    neg_in;

   always_comb begin
      logic signed [SB-1:0] sum;
      logic [SB-1:0]        abs_v;
      logic [SB-1:0]        rnd;
      for (int k = 0; k < 3; k++) begin
         if (s2_op_ff == pdq0_pkg::OP_FORWARD) begin
            case (k)
               0:       sum = SB'(s2_pc_ff[0]) + SB'(s2_pc_ff[1]) + SB'(s2_pc_ff[2]);
               1:       sum = SB'(s2_ps_ff[0]) + SB'(s2_ps_ff[1]) + SB'(s2_ps_ff[2]);
               default: sum = SB'(s2_x_ff[0]) + SB'(s2_x_ff[1]) + SB'(s2_x_ff[2]);
            endcase
         end else begin
            sum = SB'(s2_pc_ff[k]) + SB'(s2_ps_ff[k]);
         end
         neg_in[k] = sum[SB-1];
         abs_v     = sum[SB-1] ? SB'(-sum) : SB'(sum);
         if (s2_op_ff == pdq0_pkg::OP_INVERSE) begin
            rnd       = abs_v + SB'(pdq0_pkg::INV_ROUND);
            mag_in[k] = MB'(rnd >> pdq0_pkg::INV_SHIFT);
         end else if (k == 2) begin
            rnd       = abs_v + SB'(pdq0_pkg::ZERO_ROUND);
            mag_in[k] = MB'(rnd);
         end else begin
            rnd       = abs_v + SB'(pdq0_pkg::FWD_ROUND);
            mag_in[k] = MB'(rnd >> pdq0_pkg::FWD_SHIFT);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stage 3: rounded magnitudes
   // ------------------------------------------------------------------------
   logic                 s3_op_ff;
   logic [MB-1:0]        s3_mag_ff [3];
   logic [2:0]           s3_neg_ff;
   logic signed [SW-1:0] s3_x2_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s3_op_ff  <= s2_op_ff;
         s3_neg_ff <= neg_in;
         s3_x2_ff  <= s2_x_ff[2];
         for (int k = 0; k < 3; k++) begin
            s3_mag_ff[k] <= mag_in[k];
         end
      end
   end

   // divide by three on the forward path, add zero sequence on the inverse
   logic signed [SW-1:0] out_in [3];
   logic                 sat_in;

   always_comb begin
      logic [MB-1:0]        q;
      logic signed [VB-1:0] v;
      sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (s3_op_ff == pdq0_pkg::OP_FORWARD) begin
            q = pdq0_pkg::div3(s3_mag_ff[k]);
         end else begin
            q = s3_mag_ff[k];
         end
         v = s3_neg_ff[k] ? -signed'(VB'(q)) : signed'(VB'(q));
         if (s3_op_ff == pdq0_pkg::OP_INVERSE) begin
            v = v + VB'(s3_x2_ff);
         end
         if (v > VAL_MAX) begin
            out_in[k] = OUT_MAX;
            sat_in    = 1'b1;
         end else if (v < VAL_MIN) begin
            out_in[k] = OUT_MIN;
            sat_in    = 1'b1;
         end else begin
            out_in[k] = SW'(v);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stage 4: output register
   // ------------------------------------------------------------------------
   logic signed [SW-1:0] out_ff [3];
   logic                 sat_ff;

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         sat_ff <= sat_in;
         for (int k = 0; k < 3; k++) begin
            out_ff[k] <= out_in[k];
         end
      end
   end

   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata  = pdq0_pkg::OUT_TDATA_BITS'({out_ff[2], out_ff[1], out_ff[0]});
   assign rsp_tuser  = sat_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // a free output slot lets a beat in at once
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled with output slot free");

   // a result appears only from a full stage before it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(vld_ff[NSTG-2]))
      else $error("result beat without a beat in the pipeline");

   // clip flag only with an output sitting on a rail
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (out_ff[0] == OUT_MAX || out_ff[0] == OUT_MIN ||
          out_ff[1] == OUT_MAX || out_ff[1] == OUT_MIN ||
          out_ff[2] == OUT_MAX || out_ff[2] == OUT_MIN))
      else $error("saturation flag without a clipped output");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the park (dq0) transform stream unit
// drives forward and inverse beats through the request stream, predicts each
// result from its own quarter-wave sine table and fixed-point arithmetic, and
// compares every response beat field by field in order of arrival
// ----------------------------------------------------------------------------

module testbench;

   // bench sizing
   localparam int          LUT_DEPTH     = 1024;
   localparam logic [15:0] QUARTER_STEP  = 16'd16384;
   localparam logic [15:0] PHASE_STEP    = 16'd21845;
   localparam logic [63:0] HALF_PI_FIX30 = 64'd1686629713;
   localparam int          RANDOM_BEATS  = 1950;
   localparam int          DRAIN_CYCLES  = 20;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          QUIET_FROM    = 1200;
   localparam int          QUIET_TO      = 1800;
   localparam int          HOLD_AFTER    = 300;
   localparam int          HOLD_CYCLES   = 120;
   localparam int          PRINT_CAP     = 40;

   // one request beat: opcode, angle and three Q1.14 values
   typedef struct {
      logic               op;
      logic [15:0]        angle;
      logic signed [15:0] first;
      logic signed [15:0] second;
      logic signed [15:0] third;
   } phase_sample_type;

   // one response beat: three saturated values and the clip flag
   typedef struct {
      logic signed [15:0] value [3];
      logic               clipped;
   } dq0_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [pdq0_pkg::IN_TDATA_BITS-1:0]  req_tdata  = '0;
   logic                                req_tuser  = 1'b0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [pdq0_pkg::OUT_TDATA_BITS-1:0] rsp_tdata;
   logic                                rsp_tuser;

   phase_sample_type pending_samples [$];
   dq0_result_type   expected_results [$];
   longint           quarter_sine [0:LUT_DEPTH];

   int   cycle_count  = 0;
   int   error_count  = 0;
   int   results_seen = 0;
   int   hold_left    = 0;
   logic hold_done    = 1'b0;
   logic req_taken    = 1'b0;

   park_dq0_transform uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // sine of a binary angle from the quarter-wave table, Q1.14
   function automatic longint lut_sine(input logic [15:0] ang);
      int     idx;
      longint v;
      idx = (int'(ang[13:0]) * LUT_DEPTH) >> 14;
      if (idx > LUT_DEPTH) begin
         idx = LUT_DEPTH;
      end
      // odd quadrants run the table backwards, the lower half-turn is negated
      v = ang[14] ? quarter_sine[LUT_DEPTH - idx] : quarter_sine[idx];
      return ang[15] ? -v : v;
   endfunction

   // divide rounding to nearest, ties away from zero
   function automatic longint round_div(input longint num, input longint den);
      if (num >= 0) begin
         return (num + den / 2) / den;
      end
      return -((-num + den / 2) / den);
   endfunction

   // clip to 16 bits signed, clip flag on top
   function automatic logic [16:0] clamp16(input longint v);
      if (v > 32767) begin
         return {1'b1, 16'h7fff};
      end
      if (v < -32768) begin
         return {1'b1, 16'h8000};
      end
      return {1'b0, v[15:0]};
   endfunction

   function automatic dq0_result_type predict_dq0(input phase_sample_type s);
      logic [15:0]    ang [3];
      longint         x [3];
      longint         r [3];
      longint         sum_q;
      longint         sum_d;
      logic [16:0]    c;
      dq0_result_type res;
      // phase b lags by a third of a turn, phase c leads by one
      ang[0] = s.angle;
      ang[1] = s.angle - PHASE_STEP;
      ang[2] = s.angle + PHASE_STEP;
      x[0]   = s.first;
      x[1]   = s.second;
      x[2]   = s.third;
      if (s.op == pdq0_pkg::OP_FORWARD) begin
         sum_q = 0;
         sum_d = 0;
         for (int k = 0; k < 3; k++) begin
            sum_q += lut_sine(ang[k] + QUARTER_STEP) * x[k];
            sum_d += lut_sine(ang[k]) * x[k];
         end
         // 2/3 scaling folded into one divide by 3 * 2^13
         r[0] = round_div(sum_q, 3 * 8192);
         r[1] = round_div(sum_d, 3 * 8192);
         r[2] = round_div(x[0] + x[1] + x[2], 3);
      end else begin
         for (int k = 0; k < 3; k++) begin
            r[k] = round_div(lut_sine(ang[k] + QUARTER_STEP) * x[0]
                             + lut_sine(ang[k]) * x[1], 16384) + x[2];
         end
      end
      res.clipped = 1'b0;
      for (int k = 0; k < 3; k++) begin
         c            = clamp16(r[k]);
         res.value[k] = c[15:0];
         res.clipped  = res.clipped | c[16];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   task automatic queue_sample(input logic op, input logic [15:0] angle,
                               input logic signed [15:0] first,
                               input logic signed [15:0] second,
                               input logic signed [15:0] third);
      phase_sample_type s;
      s.op     = op;
      s.angle  = angle;
      s.first  = first;
      s.second = second;
      s.third  = third;
      pending_samples.push_back(s);
   endtask

   // mostly full-range values, some small, some at the rails
   function automatic logic signed [15:0] random_value();
      case ($urandom_range(5))
         0, 1, 2: return 16'($urandom);
         3:       return 16'(int'($urandom_range(16383)) - 8192);
         4:       return 16'(int'($urandom_range(4)) - 2);
         default: begin
            case ($urandom_range(3))
               0:       return 16'sh7fff;
               1:       return 16'sh8000;
               2:       return 16'sh8001;
               default: return 16'sh4000;
            endcase
         end
      endcase
   endfunction

   // angles land on quadrant and table-step edges now and then
   function automatic logic [15:0] random_angle();
      case ($urandom_range(7))
         0:       return {2'($urandom_range(3)), 14'h3fff};
         1:       return {2'($urandom_range(3)), 14'h0000};
         2:       return {2'($urandom_range(3)), 10'($urandom), 4'hf};
         default: return 16'($urandom);
      endcase
   endfunction

   // random idling on both sides, with a quiet window where nobody rests
   function automatic bit take_a_break();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) begin
         return 1'b0;
      end
      return $urandom_range(99) < 10;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // ---------------------------------------------------------------------
   // request driver: changes on the falling edge, one beat held until taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      phase_sample_type s;
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (pending_samples.size() != 0 && !take_a_break()) begin
               s = pending_samples.pop_front();
               req_tdata  <= pdq0_pkg::IN_TDATA_BITS'({s.third, s.second, s.first,
                                                        s.angle});
               req_tuser  <= s.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // response side ready: random stalls plus one long hold-off that fills
   // the pipeline and pushes back on the request side
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !take_a_break();
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: samples both handshakes on the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      phase_sample_type s;
      dq0_result_type   want;
      dq0_result_type   got;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         // accepted request beat: predict its result now
         if (req_tvalid && req_tready) begin
            s.angle  = req_tdata[15:0];
            s.first  = req_tdata[31:16];
            s.second = req_tdata[47:32];
            s.third  = req_tdata[63:48];
            s.op     = req_tuser;
            expected_results.push_back(predict_dq0(s));
         end
         // accepted response beat: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.value[0] = rsp_tdata[15:0];
            got.value[1] = rsp_tdata[31:16];
            got.value[2] = rsp_tdata[47:32];
            got.clipped  = rsp_tuser;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("response beat %0d with nothing expected",
                                         results_seen));
            end else begin
               want = expected_results.pop_front();
               for (int k = 0; k < 3; k++) begin
                  if (got.value[k] !== want.value[k]) begin
                     report_mismatch($sformatf("beat %0d output %0d got %0d want %0d",
                                               results_seen, k, got.value[k],
                                               want.value[k]));
                  end
               end
               if (got.clipped !== want.clipped) begin
                  report_mismatch($sformatf("beat %0d saturated got %0b want %0b",
                                            results_seen, got.clipped, want.clipped));
               end
            end
            results_seen++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      acc;

      // quarter-wave sine table, Taylor series in Q30 rounded half up to Q1.14
      for (int i = 0; i <= LUT_DEPTH; i++) begin
         x    = (HALF_PI_FIX30 * 64'(i)) / 64'(LUT_DEPTH);
         x2   = (x * x) >> 30;
         term = x;
         acc  = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         quarter_sine[i] = longint'((64'(acc) + 64'd32768) >> 16);
      end

      // directed: all-zero, balanced three-phase, rails, clipping both ways
      queue_sample(pdq0_pkg::OP_FORWARD, 16'h0000, 16'sd0, 16'sd0, 16'sd0);
      queue_sample(pdq0_pkg::OP_FORWARD, 16'h0000, 16'sd16384, -16'sd8192, -16'sd8192);
      queue_sample(pdq0_pkg::OP_FORWARD, 16'h4000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      queue_sample(pdq0_pkg::OP_FORWARD, 16'hffff, 16'sh8000, 16'sh8000, 16'sh8000);
      queue_sample(pdq0_pkg::OP_FORWARD, 16'h0000, 16'sh7fff, 16'sh8000, 16'sh8000);
      queue_sample(pdq0_pkg::OP_FORWARD, 16'h8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
      // zero-sequence rounding just either side of the halfway point
      queue_sample(pdq0_pkg::OP_FORWARD, 16'h1234, -16'sd1, 16'sd0, 16'sd0);
      queue_sample(pdq0_pkg::OP_FORWARD, 16'h1234, -16'sd1, -16'sd1, 16'sd0);
      queue_sample(pdq0_pkg::OP_FORWARD, 16'h1234, 16'sd1, 16'sd1, 16'sd0);
      // the last table step before the first two quadrant edges, and the third quadrant edge
      queue_sample(pdq0_pkg::OP_FORWARD, 16'h3fff, 16'sd12000, -16'sd3000, -16'sd9000);
      queue_sample(pdq0_pkg::OP_FORWARD, 16'h7fff, 16'sd12000, -16'sd3000, -16'sd9000);
      queue_sample(pdq0_pkg::OP_FORWARD, 16'hc000, 16'sd12000, -16'sd3000, -16'sd9000);
      // inverse: pure q, passthrough of zero, clipping high and low
      queue_sample(pdq0_pkg::OP_INVERSE, 16'h0000, 16'sd16384, 16'sd0, 16'sd0);
      queue_sample(pdq0_pkg::OP_INVERSE, 16'hffff, 16'sd0, 16'sd0, 16'sh8000);
      queue_sample(pdq0_pkg::OP_INVERSE, 16'hc000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      queue_sample(pdq0_pkg::OP_INVERSE, 16'h4000, 16'sh8000, 16'sh8000, 16'sh8000);
      // inverse at the phase-offset angles and around the wrap
      queue_sample(pdq0_pkg::OP_INVERSE, PHASE_STEP, 16'sd10000, -16'sd7000, 16'sd5);
      queue_sample(pdq0_pkg::OP_INVERSE, 16'(-PHASE_STEP), -16'sd10000, 16'sd7000,
                   -16'sd5);
      queue_sample(pdq0_pkg::OP_INVERSE, 16'h8000, 16'sd16384, 16'sd16384, 16'sd0);
      queue_sample(pdq0_pkg::OP_INVERSE, 16'h2001, 16'sd3, -16'sd3, 16'sh7ffe);
      queue_sample(pdq0_pkg::OP_INVERSE, 16'hbfff, 16'sh7fff, 16'sh8000, 16'sd0);

      // random: both opcodes, full angle range, mixed value shapes
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         queue_sample(1'($urandom_range(1)), random_angle(), random_value(),
                      random_value(), random_value());
      end

      // synchronous reset, released on a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_samples.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
